// ===== design/dual_stepper_phase_sequencer_assert.svh =====
// assertion macros for the dual stepper phase sequencer
// no dependencies; included by the top level, which checks its own logic
`ifndef DUAL_STEPPER_PHASE_SEQUENCER_ASSERT_SVH
`define DUAL_STEPPER_PHASE_SEQUENCER_ASSERT_SVH

// same-cycle implication, ignored while in reset
`define DSPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsps check failed");

// next-cycle implication, ignored while in reset
`define DSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsps check failed");

`endif

// ===== design/dsps_pkg.sv =====
// shared types, codes and tables of the dual stepper phase sequencer
// no dependencies; imported by dsps_motor and the top level
package dsps_pkg;

    localparam int SINE_STEPS = 32;
    localparam int PHASE_W    = 5;
    localparam int TIME_W     = 32;
    localparam int PWM_W      = 8;
    localparam int COILS_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_CLR_COUNT = 2'd1,
        KIND_CLR_PHASE = 2'd2,
        KIND_RESTART   = 2'd3
    } kind_t;

    // step mode codes; code 3 behaves as microstep
    localparam logic [1:0] STEP_FULL  = 2'd0;
    localparam logic [1:0] STEP_HALF  = 2'd1;
    localparam logic [1:0] STEP_MICRO = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_DIR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DIR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MODE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_MODE    = 3'd5;

    localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(SINE_STEPS / 4);

    localparam logic [PWM_W-1:0] SINE_LUT [SINE_STEPS] = '{
        8'd128, 8'd152, 8'd176, 8'd198, 8'd218, 8'd234, 8'd245, 8'd253,
        8'd255, 8'd253, 8'd245, 8'd234, 8'd218, 8'd198, 8'd176, 8'd152,
        8'd128, 8'd103, 8'd79,  8'd57,  8'd37,  8'd21,  8'd10,  8'd2,
        8'd0,   8'd2,   8'd10,  8'd21,  8'd37,  8'd57,  8'd79,  8'd103
    };

    // coil bits: bit0 A+, bit1 A-, bit2 B+, bit3 B-
    localparam logic [COILS_W-1:0] FULL_LUT [4] = '{4'h5, 4'h6, 4'hA, 4'h9};
    localparam logic [COILS_W-1:0] HALF_LUT [8] = '{
        4'h5, 4'h4, 4'h6, 4'h2, 4'hA, 4'h8, 4'h9, 4'h1
    };

    typedef struct packed {
        logic       load;       // item transfer this cycle
        logic       drive;      // tick item with brake hold
        logic       clr_phase;  // clear phase index
        logic       restart;    // clear phase and restart step timer
        logic [1:0] mode;       // step mode code
    } dsps_ctl_t;

endpackage

// ===== design/dsps_motor.sv =====
// one motor channel: phase index, step timer and coil pattern
// depends on dsps_pkg
module dsps_motor
    import dsps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dsps_ctl_t             ctl,
    input  logic [TIME_W-1:0]     period,
    input  logic [1:0]            direction,
    input  logic [PWM_W-1:0]      pwm,
    input  logic [TIME_W-1:0]     now,
    output logic [COILS_W-1:0]    coils,
    output logic [PHASE_W-1:0]    phase_next,
    output logic                  step
);

    logic [PHASE_W-1:0] phase_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic [TIME_W-1:0]  last_time_next;
    logic [TIME_W-1:0]  elapsed;
    logic [PHASE_W-1:0] mask;
    logic [PHASE_W-1:0] idx;
    logic [PHASE_W-1:0] phase_adv;
    logic [PWM_W-1:0]   va;
    logic [PWM_W-1:0]   vb;
    logic [COILS_W-1:0] pattern;

    always_comb
    begin
        unique case (ctl.mode)
            STEP_FULL: mask = PHASE_W'(3);
            STEP_HALF: mask = PHASE_W'(7);
            default:   mask = PHASE_W'(SINE_STEPS - 1);
        endcase
    end

    assign idx       = phase_reg & mask;
    assign elapsed   = now - last_time_reg;
    assign step      = ctl.drive && (elapsed >= period);
    assign phase_adv = (phase_reg + {{(PHASE_W-2){direction[1]}}, direction}) & mask;

    // coil pattern from the phase before it advances
    assign va = SINE_LUT[idx];
    assign vb = SINE_LUT[idx + QUARTER_TURN];

    always_comb
    begin
        unique case (ctl.mode)
            STEP_FULL: pattern = FULL_LUT[idx[1:0]];
            STEP_HALF: pattern = HALF_LUT[idx[2:0]];
            default:   pattern = {pwm < ~vb, pwm < vb, pwm < ~va, pwm < va};
        endcase
    end

    assign coils = ctl.drive ? pattern : '0;

    always_comb
    begin
        phase_next     = phase_reg;
        last_time_next = last_time_reg;
        if (ctl.restart)
        begin
            phase_next     = '0;
            last_time_next = now;
        end
        else if (ctl.clr_phase)
        begin
            phase_next = '0;
        end
        else if (step)
        begin
            phase_next     = phase_adv;
            last_time_next = now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            last_time_reg <= '0;
        end
        else if (ctl.load)
        begin
            phase_reg     <= phase_next;
            last_time_reg <= last_time_next;
        end
    end

endmodule

// ===== design/dual_stepper_phase_sequencer.sv =====
// Dual stepper phase sequencer: drives two four-input stepper bridges.
// Input stream s_*: one item per transfer; tuser carries the item kind
// (tick, clear step counts, clear phases, restart all), tdata the PWM
// counter and timer value. Output stream m_*: one result per item with both
// coil patterns, both phase indexes and the halved sum of the step counts.
// A result is registered and presented in the cycle after its input
// transfer. One item per cycle is taken while the receiver keeps up; the
// state update and the result are formed in the same cycle the item is
// taken, straight into the output register.
// When the receiver stalls with a result waiting, s_tready drops until that
// result is taken; nothing is lost or repeated.
// Registers are written via cfg_wr_en / cfg_index / cfg_data, by the user only
// while the stream is idle (not enforced); a zero period is stored as one.
// Reset: phases, step timers and step counts clear, periods return to 500,
// directions to +1 (left) and -1 (right), brake hold and microstep mode.
// Depends on dsps_pkg, dsps_motor and the assertion macro header.
`include "dual_stepper_phase_sequencer_assert.svh"

module dual_stepper_phase_sequencer
    import dsps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // pwm_phase[7:0], tick_time[39:8]
    input  logic [1:0]            s_tuser,   // kind[1:0]
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // left_coils[3:0], right_coils[7:4], left_phase[12:8],
    // right_phase[17:13], executed_steps[48:18], zero fill[55:49]
    output logic [55:0]           m_tdata,
    // register writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [TIME_W-1:0] left_period_reg;
    logic [TIME_W-1:0] right_period_reg;
    logic [1:0]        left_dir_reg;
    logic [1:0]        right_dir_reg;
    logic              hold_mode_reg;
    logic [1:0]        step_mode_reg;

    logic [TIME_W-1:0] total_steps_reg;
    logic [TIME_W-1:0] total_steps_next;
    logic              m_tvalid_reg;
    logic [55:0]       m_tdata_reg;
    logic [55:0]       m_tdata_next;

    logic              accept;
    kind_t             kind;
    logic [PWM_W-1:0]  pwm;
    logic [TIME_W-1:0] now;
    dsps_ctl_t         ctl;
    logic [TIME_W-1:0] cfg_period;
    logic [1:0]        cfg_dir;

    logic [COILS_W-1:0] left_coils;
    logic [COILS_W-1:0] right_coils;
    logic [PHASE_W-1:0] left_phase;
    logic [PHASE_W-1:0] right_phase;
    logic               left_step;
    logic               right_step;

    assign kind     = kind_t'(s_tuser);
    assign pwm      = s_tdata[7:0];
    assign now      = s_tdata[39:8];
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        ctl.load      = accept;
        ctl.drive     = (kind == KIND_TICK) && hold_mode_reg;
        ctl.clr_phase = (kind == KIND_CLR_PHASE) || (kind == KIND_RESTART);
        ctl.restart   = (kind == KIND_RESTART);
        ctl.mode      = step_mode_reg;
    end

    dsps_motor u_left (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .period     (left_period_reg),
        .direction  (left_dir_reg),
        .pwm        (pwm),
        .now        (now),
        .coils      (left_coils),
        .phase_next (left_phase),
        .step       (left_step)
    );

    dsps_motor u_right (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .period     (right_period_reg),
        .direction  (right_dir_reg),
        .pwm        (pwm),
        .now        (now),
        .coils      (right_coils),
        .phase_next (right_phase),
        .step       (right_step)
    );

    // only the sum of both step counts is ever observed
    always_comb
    begin
        if ((kind == KIND_CLR_COUNT) || (kind == KIND_RESTART))
            total_steps_next = '0;
        else
            total_steps_next = total_steps_reg + TIME_W'(left_step) + TIME_W'(right_step);
    end

    assign m_tdata_next = {7'd0, total_steps_next[TIME_W-1:1], right_phase, left_phase,
                           right_coils, left_coils};

    // config decode
    assign cfg_period = (cfg_data == '0) ? TIME_W'(1) : cfg_data;

    always_comb
    begin
        unique case (cfg_data[1:0])
            2'b00:   cfg_dir = 2'b00;
            2'b01:   cfg_dir = 2'b01;
            default: cfg_dir = 2'b11;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_period_reg  <= TIME_W'(500);
            right_period_reg <= TIME_W'(500);
            left_dir_reg     <= 2'b01;
            right_dir_reg    <= 2'b11;
            hold_mode_reg    <= 1'b1;
            step_mode_reg    <= STEP_MICRO;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LEFT_PERIOD:  left_period_reg  <= cfg_period;
                REG_RIGHT_PERIOD: right_period_reg <= cfg_period;
                REG_LEFT_DIR:     left_dir_reg     <= cfg_dir;
                REG_RIGHT_DIR:    right_dir_reg    <= cfg_dir;
                REG_HOLD_MODE:    hold_mode_reg    <= cfg_data[0];
                REG_STEP_MODE:    step_mode_reg    <= cfg_data[1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_steps_reg <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                total_steps_reg <= total_steps_next;
                m_tvalid_reg    <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `DSPS_ASSERT_NOW(a_no_take_when_blocked, clk, rst_n, m_tvalid && !m_tready, !s_tready)
    `DSPS_ASSERT_NEXT(a_result_follows, clk, rst_n, accept, m_tvalid)
    `DSPS_ASSERT_NEXT(a_idle_coils_low, clk, rst_n, accept && !ctl.drive, m_tdata[7:0] == 8'd0)
    `DSPS_ASSERT_NOW(a_period_nonzero, clk, rst_n, 1'b1,
        (left_period_reg != '0) && (right_period_reg != '0))

endmodule
